// ===== design/wake_command_beacon_timer_top_macros.svh =====
// Assertion macros for the wake command beacon timer.
// Define ASSERT_OFF to compile the assertions out.
`ifndef WAKE_COMMAND_BEACON_TIMER_TOP_MACROS_SVH
`define WAKE_COMMAND_BEACON_TIMER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define WCBT_ASSERT_IMPLIES(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("wcbt assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define WCBT_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("wcbt assertion failed");
`else
`define WCBT_ASSERT_IMPLIES(label, clk_sig, rstn_sig, ante, cons)
`define WCBT_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)
`endif
`endif

// ===== design/wcbt_pkg.sv =====
// ----------------------------------------------------------------------------
// wcbt_pkg: shared types and constants
// Item formats, register indexes and command byte values of the wake
// command parser and beacon timer.
// ----------------------------------------------------------------------------
`default_nettype none

package wcbt_pkg;

    // Command bytes of the wake command A5 01 01 5A.
    localparam logic [7:0] HEADER_BYTE = 8'hA5;
    localparam logic [7:0] CMD_BYTE1   = 8'h01;
    localparam logic [7:0] CMD_BYTE2   = 8'h01;
    localparam logic [7:0] TRAILER     = 8'h5A;

    // Register reset values and counter ceiling.
    localparam logic [15:0] DUR_RESET = 16'd15000;
    localparam logic [15:0] INT_RESET = 16'd40;
    localparam logic [15:0] CNT_MAX   = 16'hFFFF;

    // Configuration register indexes.
    localparam int          REG_INDEX_W = 2;
    localparam int          REG_DATA_W  = 16;
    localparam logic [1:0]  REG_WAKE_DURATION   = 2'd0;
    localparam logic [1:0]  REG_BEACON_INTERVAL = 2'd1;

    // Item opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } wcbt_in_t;

    typedef struct packed {
        logic send_beacon;
        logic wake_active;
        logic command_accepted;
        logic command_rejected;
    } wcbt_out_t;

    // Occupancy of the output buffer.
    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } wcbt_buf_status_t;

endpackage

`default_nettype wire

// ===== design/wcbt_core.sv =====
// ----------------------------------------------------------------------------
// wcbt_core: command parser and wake window timer
// Holds the parser and timer state and the configuration registers, and
// computes the result of each accepted item in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module wcbt_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_fire,
    input  wire wcbt_pkg::wcbt_in_t              in_item,
    input  wire logic                            wr_en,
    input  wire logic [wcbt_pkg::REG_INDEX_W-1:0] wr_index,
    input  wire logic [wcbt_pkg::REG_DATA_W-1:0]  wr_data,
    output wcbt_pkg::wcbt_out_t                  result
);
    import wcbt_pkg::*;

    logic [15:0] duration_reg;
    logic [15:0] interval_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [7:0]  cmd0_reg, cmd0_next;
    logic [7:0]  cmd1_reg, cmd1_next;
    logic        running_reg, running_next;
    logic [15:0] trig_reg, trig_next;
    logic [15:0] beac_reg, beac_next;
    logic [15:0] trig_inc;
    logic [15:0] beac_inc;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= DUR_RESET;
            interval_reg <= INT_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_WAKE_DURATION)
                duration_reg <= wr_data;
            else if (wr_index == REG_BEACON_INTERVAL)
                interval_reg <= wr_data;
        end
    end

    // Saturating increments of the tick counters.
    assign trig_inc = (trig_reg == CNT_MAX) ? trig_reg : trig_reg + 16'd1;
    assign beac_inc = (beac_reg == CNT_MAX) ? beac_reg : beac_reg + 16'd1;

    // Next state and result of the current item.
    always_comb
    begin
        pos_next     = pos_reg;
        cmd0_next    = cmd0_reg;
        cmd1_next    = cmd1_reg;
        running_next = running_reg;
        trig_next    = trig_reg;
        beac_next    = beac_reg;
        result       = '0;
        if (in_item.op == OP_BYTE)
        begin
            unique case (pos_reg)
                2'd0:
                begin
                    if (in_item.rx_byte == HEADER_BYTE)
                        pos_next = 2'd1;
                end
                2'd1:
                begin
                    cmd0_next = in_item.rx_byte;
                    pos_next  = 2'd2;
                end
                2'd2:
                begin
                    cmd1_next = in_item.rx_byte;
                    pos_next  = 2'd3;
                end
                default:
                begin
                    pos_next = 2'd0;
                    if (cmd0_reg == CMD_BYTE1 && cmd1_reg == CMD_BYTE2 &&
                        in_item.rx_byte == TRAILER)
                    begin
                        result.command_accepted = 1'b1;
                        running_next = 1'b1;
                        trig_next    = '0;
                        beac_next    = CNT_MAX;
                    end
                    else
                    begin
                        result.command_rejected = 1'b1;
                    end
                end
            endcase
        end
        else if (running_reg)
        begin
            trig_next = trig_inc;
            beac_next = beac_inc;
            if (trig_inc >= duration_reg)
            begin
                running_next = 1'b0;
            end
            else if (beac_inc >= interval_reg)
            begin
                result.send_beacon = 1'b1;
                beac_next = '0;
            end
        end
        result.wake_active = running_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 2'd0;
            running_reg <= 1'b0;
            trig_reg    <= '0;
            beac_reg    <= '0;
        end
        else if (in_fire)
        begin
            pos_reg     <= pos_next;
            running_reg <= running_next;
            trig_reg    <= trig_next;
            beac_reg    <= beac_next;
        end
    end

    // Command bytes carry no reset; they are written before being compared.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd0_reg <= cmd0_next;
            cmd1_reg <= cmd1_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/wcbt_out_buf.sv =====
// ----------------------------------------------------------------------------
// wcbt_out_buf: two-entry output buffer
// Output register with a skid entry, so an item can be accepted in the
// same cycle in which a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module wcbt_out_buf (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_fire,
    input  wire wcbt_pkg::wcbt_out_t       in_item,
    output logic                           in_stall,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output wcbt_pkg::wcbt_out_t            out_item,
    output wcbt_pkg::wcbt_buf_status_t     status
);
    import wcbt_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    wcbt_out_t main_reg, main_next;
    wcbt_out_t skid_reg, skid_next;
    logic      out_take;

    assign out_take = main_valid_reg && !out_stall;

    // Refill the output register from the skid entry first, else from input.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_item;
                main_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next       = in_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_stall          = skid_valid_reg;
    assign out_valid         = main_valid_reg;
    assign out_item          = main_reg;
    assign status.main_valid = main_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

`default_nettype wire

// ===== design/wake_command_beacon_timer_top.sv =====
// A result is registered in the output buffer's main register, or in its skid entry while the output stalls.
// Throughput: one item per cycle while the skid entry is empty; the parser and timer update in a single pass.
// A two-entry output buffer keeps accepting while one result waits on a stall.
// Reset: asynchronous and active low; the parser hunts for a header, the window
// is idle, both counters are zero and the registers hold 15000 and 40.
// ----------------------------------------------------------------------------
// wake_command_beacon_timer_top: wake command parser and beacon timer
// Parses 4-byte serial commands and runs the wake window and beacon
// schedule on millisecond ticks.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wake_command_beacon_timer_top_macros.svh"

module wake_command_beacon_timer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire wcbt_pkg::wcbt_in_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output wcbt_pkg::wcbt_out_t                   out_data,
    input  wire logic                             wr_en,
    input  wire logic [wcbt_pkg::REG_INDEX_W-1:0] wr_index,
    input  wire logic [wcbt_pkg::REG_DATA_W-1:0]  wr_data
);
    import wcbt_pkg::*;

    logic             in_fire;
    wcbt_out_t        core_result;
    wcbt_buf_status_t buf_status;

    assign in_fire = in_valid && !in_stall;

    // Parser, timer and configuration registers.
    wcbt_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_item  (in_data),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .result   (core_result)
    );

    // Output register with skid entry.
    wcbt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_item   (core_result),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_data),
        .status    (buf_status)
    );

    // The skid entry is only used behind a full output register.
    `WCBT_ASSERT_IMPLIES(a_skid_behind_main, clk, rst_n, buf_status.skid_valid, buf_status.main_valid)
    // A result never both accepts and rejects a command.
    `WCBT_ASSERT_IMPLIES(a_flags_exclusive, clk, rst_n, out_valid, !(out_data.command_accepted && out_data.command_rejected))
    // Beacons and accepted commands happen only with the window running.
    `WCBT_ASSERT_IMPLIES(a_active_on_event, clk, rst_n, out_valid && (out_data.send_beacon || out_data.command_accepted), out_data.wake_active)
    // A stalled result stays on the output in the next cycle.
    `WCBT_ASSERT_NEXT(a_stalled_result_held, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

`default_nettype wire

// ===== sim/wake_command_beacon_timer_checker.sv =====
// ----------------------------------------------------------------------------
// wake_command_beacon_timer_checker: result checker for the wake timer
// Watches the item channels and the register port of the wake command
// parser and beacon timer, predicts the status of every accepted item and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module wake_command_beacon_timer_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire wcbt_pkg::wcbt_in_t               in_data,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire wcbt_pkg::wcbt_out_t              out_data,
    input  wire logic                             wr_en,
    input  wire logic [wcbt_pkg::REG_INDEX_W-1:0] wr_index,
    input  wire logic [wcbt_pkg::REG_DATA_W-1:0]  wr_data,
    output int                                    mismatches,
    output int                                    outstanding
);

    import wcbt_pkg::*;

    // Shadow registers.
    logic [15:0] wake_duration;
    logic [15:0] beacon_interval;

    // Shadow parser and timer state.
    logic [1:0]  cmd_pos;
    logic [7:0]  cmd_byte [2];
    logic        window_on;
    logic [15:0] trigger_age;
    logic [15:0] beacon_age;

    // Status words predicted for items that have not come out yet.
    wcbt_out_t   pending_status [$];
    int          result_count;

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s: expected %0b, got %0b",
                                      result_count, field, want, got));
        end
    endtask

    // Advance the shadow state by one item and return the status it causes.
    task automatic step_wake_status(input wcbt_in_t item, output wcbt_out_t status);
        status = '0;
        if (item.op == OP_BYTE)
        begin
            if (cmd_pos == 2'd0)
            begin
                // Hunting: anything but the header is dropped.
                if (item.rx_byte == HEADER_BYTE)
                    cmd_pos = 2'd1;
            end
            else if (cmd_pos != 2'd3)
            begin
                cmd_byte[int'(cmd_pos) - 1] = item.rx_byte;
                cmd_pos = cmd_pos + 2'd1;
            end
            else
            begin
                // Fourth byte closes the command either way.
                cmd_pos = 2'd0;
                if (cmd_byte[0] == CMD_BYTE1 && cmd_byte[1] == CMD_BYTE2 &&
                    item.rx_byte == TRAILER)
                begin
                    status.command_accepted = 1'b1;
                    window_on   = 1'b1;
                    trigger_age = '0;
                    beacon_age  = CNT_MAX;
                end
                else
                begin
                    status.command_rejected = 1'b1;
                end
            end
        end
        else if (window_on)
        begin
            // Both counters saturate at the ceiling.
            if (trigger_age != CNT_MAX)
                trigger_age = trigger_age + 16'd1;
            if (beacon_age != CNT_MAX)
                beacon_age = beacon_age + 16'd1;
            if (trigger_age >= wake_duration)
            begin
                window_on = 1'b0;
            end
            else if (beacon_age >= beacon_interval)
            begin
                status.send_beacon = 1'b1;
                beacon_age = '0;
            end
        end
        status.wake_active = window_on;
    endtask

    // Track register writes, compare results and predict new items.
    always @(posedge clk or negedge rst_n)
    begin
        wcbt_out_t predicted;
        wcbt_out_t oldest;
        if (!rst_n)
        begin
            wake_duration   = DUR_RESET;
            beacon_interval = INT_RESET;
            cmd_pos         = 2'd0;
            cmd_byte[0]     = '0;
            cmd_byte[1]     = '0;
            window_on       = 1'b0;
            trigger_age     = '0;
            beacon_age      = '0;
            pending_status.delete();
            result_count    = 0;
            mismatches      = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_WAKE_DURATION:   wake_duration   = wr_data;
                    REG_BEACON_INTERVAL: beacon_interval = wr_data;
                    default: ;
                endcase
            end

            // A result leaving now belongs to an item accepted earlier.
            if (out_valid && !out_stall)
            begin
                if (pending_status.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                end
                else
                begin
                    oldest = pending_status.pop_front();
                    check_field("send_beacon", oldest.send_beacon, out_data.send_beacon);
                    check_field("wake_active", oldest.wake_active, out_data.wake_active);
                    check_field("command_accepted", oldest.command_accepted,
                                out_data.command_accepted);
                    check_field("command_rejected", oldest.command_rejected,
                                out_data.command_rejected);
                end
                result_count++;
            end

            if (in_valid && !in_stall)
            begin
                step_wake_status(in_data, predicted);
                pending_status.push_back(predicted);
            end

            outstanding <= pending_status.size();
        end
    end

endmodule

// ===== sim/wake_command_beacon_timer_top_tb.sv =====
// ----------------------------------------------------------------------------
// wake_command_beacon_timer_top_tb: testbench for the wake command timer
// Drives serial bytes and millisecond ticks through the block under several
// register settings and idling patterns; a separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------

module wake_command_beacon_timer_top_tb;

    import wcbt_pkg::*;

    localparam int QUIET_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 165;

    // Indexes past the last register; writes there must be ignored.
    localparam logic [REG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_BEACON_INTERVAL + 2'd1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    wcbt_in_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    wcbt_out_t              out_data;
    logic                   wr_en     = 1'b0;
    logic [REG_INDEX_W-1:0] wr_index  = '0;
    logic [REG_DATA_W-1:0]  wr_data   = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    int mismatches;
    int outstanding;

    wake_command_beacon_timer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    wake_command_beacon_timer_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Give up when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one item, after a random idle gap, and wait until it is taken.
    task automatic send_item(input logic op, input logic [7:0] data);
        wcbt_in_t item;
        item.op      = op;
        item.rx_byte = data;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(OP_TICK, 8'($urandom));
    endtask

    // A wake command; when damaged, each byte after the header may be garbled.
    task automatic send_command(input bit intact);
        logic [7:0] body [3];
        body[0] = CMD_BYTE1;
        body[1] = CMD_BYTE2;
        body[2] = TRAILER;
        send_item(OP_BYTE, HEADER_BYTE);
        for (int i = 0; i < 3; i++)
        begin
            if (!intact && $urandom_range(1))
                body[i] = 8'($urandom);
            send_item(OP_BYTE, body[i]);
        end
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Registers change only while the block is idle.
    task automatic set_registers(input logic [15:0] duration, input logic [15:0] interval);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= REG_WAKE_DURATION;
        wr_data  <= duration;
        @(posedge clk);
        wr_index <= REG_BEACON_INTERVAL;
        wr_data  <= interval;
        @(posedge clk);
        wr_index <= REG_FIRST_UNUSED + REG_INDEX_W'($urandom_range(1));
        wr_data  <= 16'($urandom);
        @(posedge clk);
        wr_en    <= 1'b0;
        @(posedge clk);
    endtask

    // Idling modes: none, sender only, receiver only, both.
    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct <= 0;  stall_pct <= 0;  end
            1:       begin send_idle_pct <= 78; stall_pct <= 0;  end
            2:       begin send_idle_pct <= 0;  stall_pct <= 78; end
            default: begin send_idle_pct <= 33; stall_pct <= 33; end
        endcase
    endtask

    // Mostly well-formed commands and tick bursts, with damaged commands
    // and stray bytes mixed in.
    task automatic run_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                send_command(1'b1);
            else if (pick < 50)
                send_command(1'b0);
            else if (pick < 90)
                send_ticks($urandom_range(1, 8));
            else
                send_item(OP_BYTE, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: short window, beacon every second tick.
        set_registers(16'd4, 16'd2);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_command(1'b1);
        send_ticks(4);
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_BYTE, CMD_BYTE1);
        send_item(OP_BYTE, 8'h02);
        send_item(OP_BYTE, TRAILER);
        // Start the window again, then retrigger it while it runs.
        send_command(1'b1);
        send_ticks(1);
        send_command(1'b1);
        send_ticks(1);

        // Random part over several register settings and idling modes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       set_registers(16'd30, 16'd5);
                1:       set_registers(16'd0, 16'd0);
                2:       set_registers(16'hFFFF, 16'd1);
                3:       set_registers(16'd1, 16'hFFFF);
                4:       set_registers(16'($urandom_range(1, 60)), 16'($urandom_range(12)));
                5:       set_registers(16'hFFFF, 16'hFFFF);
                6:       set_registers(16'($urandom_range(2, 200)),
                                       16'($urandom_range(1, 20)));
                default: set_registers(16'd12, 16'd3);
            endcase
            set_idling(phase % 4);
            run_traffic(ITEMS_PER_PHASE / 2);
            // Let the block run dry before carrying on.
            wait_drained();
            run_traffic(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== wake_command_beacon_timer_top.f =====
+incdir+design
design/wcbt_pkg.sv
design/wcbt_core.sv
design/wcbt_out_buf.sv
design/wake_command_beacon_timer_top.sv
sim/wake_command_beacon_timer_checker.sv
sim/wake_command_beacon_timer_top_tb.sv
